/* rtl/mpfa_pkg.sv */
// Package for the float64 array serializer: payload structs, constants,
// and the single-to-double widening function. No dependencies.
package mpfa_pkg;

   localparam logic OP_START = 1'b0;
   localparam logic OP_VALUE = 1'b1;

   localparam logic [31:0] HDR_FIX_MAX = 32'h0000_000F;
   localparam logic [7:0]  HDR_FIX     = 8'h90;
   localparam logic [31:0] HDR_16_MAX  = 32'h0000_FFFF;
   localparam logic [7:0]  HDR_16      = 8'hDC;
   localparam logic [7:0]  HDR_32      = 8'hDD;
   localparam logic [7:0]  TAG_F64     = 8'hCB;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        opcode;
      logic [19:0] value_count;
      logic [63:0] time_bits;
      logic [31:0] value_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
   } rsp_type;

   // job handed from front to back: up to 5 header bytes then one float64
   typedef struct packed {
      logic [39:0] hdr_bytes;
      logic [2:0]  hdr_len;
      logic [63:0] f64_bits;
   } job_type;

   function automatic logic [63:0] widen_single(input logic [31:0] f);
      logic [7:0]  e;
      logic [22:0] m;
      logic [4:0]  p;
      logic [22:0] sh;
      logic [10:0] ex;
      logic [63:0] r;
      e  = f[30:23];
      m  = f[22:0];
      p  = 5'd0;
      sh = 23'd0;
      ex = 11'd0;
      r  = '0;
      r[63] = f[31];
      if (e == 8'hFF) begin
         r[62:52] = 11'h7FF;
         r[51:29] = m;
         if (m != 23'd0) r[51] = 1'b1;
      end else if (e == 8'd0) begin
         if (m != 23'd0) begin
            for (int i = 0; i < 23; i++) begin
               if (m[i]) p = 5'(i);
            end
            sh = m << (5'd23 - p);
            ex = 11'd874 + 11'(p);
            r[62:52] = ex;
            r[51:29] = sh;
         end
      end else begin
         r[62:52] = 11'(e) + 11'd896;
         r[51:29] = m;
      end
      return r;
   endfunction

endpackage

/* rtl/mpfa_front.sv */
// Front: accepts request items and classifies them into byte jobs.
// Depends on mpfa_pkg.
module mpfa_front import mpfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);
   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic [31:0] cnt;

   assign req_ready = !valid_ff || job_ready;
   assign job_valid = valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      cnt = 32'(req_data.value_count) + 32'd1;
      job_in = '0;
      if (req_data.opcode == OP_START) begin
         job_in.f64_bits = req_data.time_bits;
         if (cnt <= HDR_FIX_MAX) begin
            job_in.hdr_bytes = {HDR_FIX | cnt[7:0], 32'd0};
            job_in.hdr_len = 3'd1;
         end else if (cnt <= HDR_16_MAX) begin
            job_in.hdr_bytes = {HDR_16, cnt[15:0], 16'd0};
            job_in.hdr_len = 3'd3;
         end else begin
            job_in.hdr_bytes = {HDR_32, cnt};
            job_in.hdr_len = 3'd5;
         end
      end else begin
         job_in.f64_bits = widen_single(req_data.value_bits);
      end
      valid_in = valid_ff;
      if (req_ready) valid_in = req_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (req_valid && req_ready) job_ff <= job_in;
   end
endmodule

/* rtl/mpfa_queue.sv */
// Short queue between front and back halves.
// Depends on mpfa_pkg.
module mpfa_queue import mpfa_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   job_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

/* rtl/mpfa_back.sv */
// Back: serializes one job into bytes, one transfer per cycle while rsp_ready is high.
// Depends on mpfa_pkg.
module mpfa_back import mpfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   // stream: header bytes, tag, eight data bytes
   logic [3:0] idx_ff, idx_in;
   logic [3:0] total;
   logic [3:0] pos;
   logic [7:0] b;
   logic       last;

   assign total = 4'(job_data.hdr_len) + 4'd9;
   assign rsp_valid = job_valid;
   assign last = idx_ff == total - 4'd1;
   assign job_ready = rsp_ready && last;

   always_comb begin
      pos = idx_ff - 4'(job_data.hdr_len);
      case (idx_ff)
         4'd0: b = job_data.hdr_bytes[39:32];
         4'd1: b = job_data.hdr_bytes[31:24];
         4'd2: b = job_data.hdr_bytes[23:16];
         4'd3: b = job_data.hdr_bytes[15:8];
         4'd4: b = job_data.hdr_bytes[7:0];
         default: b = 8'd0;
      endcase
      if (idx_ff >= 4'(job_data.hdr_len)) begin
         case (pos)
            4'd0: b = TAG_F64;
            4'd1: b = job_data.f64_bits[63:56];
            4'd2: b = job_data.f64_bits[55:48];
            4'd3: b = job_data.f64_bits[47:40];
            4'd4: b = job_data.f64_bits[39:32];
            4'd5: b = job_data.f64_bits[31:24];
            4'd6: b = job_data.f64_bits[23:16];
            4'd7: b = job_data.f64_bits[15:8];
            default: b = job_data.f64_bits[7:0];
         endcase
      end
      rsp_data.out_byte = b;
      rsp_data.run_last = last;
      idx_in = idx_ff;
      if (job_valid && rsp_ready) idx_in = last ? 4'd0 : idx_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 4'd0;
      else idx_ff <= idx_in;
   end
endmodule

/* rtl/msgpack_float_array_encoder_core.sv */
// channel | dir | payload  | handshake
// req     | in  | req_type | req_valid / req_ready
// rsp     | out | rsp_type | rsp_valid / rsp_ready
// Value item: 9 bytes; start item: 10, 12 or 14 bytes.
// Rate set by the back serializer, one byte per cycle on rsp while rsp_ready is high.
// Front register and queue accept items while the back drains.
// Synchronous active-high reset clears valid flags and counters.
// Depends on mpfa_pkg, mpfa_front, mpfa_queue, mpfa_back.
module msgpack_float_array_encoder_core import mpfa_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   logic    f_valid, f_ready, q_valid, q_ready;
   job_type f_data, q_data;

   mpfa_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .job_valid(f_valid), .job_ready(f_ready), .job_data(f_data)
   );
   mpfa_queue #(.DEPTH(DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );
   mpfa_back u_back (
      .clock, .reset,
      .job_valid(q_valid), .job_ready(q_ready), .job_data(q_data),
      .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

/* rtl/mpfa_checker.sv */
// Port-level checks for the serializer core.
// Depends on mpfa_pkg and the top-level ports.
module mpfa_checker import mpfa_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // hold stalled output
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");
   // no output right after reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
   // a run ends before a new tag byte: after last, next byte starts a header or tag
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.run_last ##1 rsp_valid |->
      rsp_data.out_byte[7:4] == 4'h9 || rsp_data.out_byte == HDR_16 ||
      rsp_data.out_byte == HDR_32 || rsp_data.out_byte == TAG_F64)
      else $error("run did not start with header or tag");
   // idle pipeline accepts input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(req_valid) |-> req_ready)
      else $error("idle block not ready");
endmodule

bind msgpack_float_array_encoder_core mpfa_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .req_data,
   .rsp_valid, .rsp_ready, .rsp_data
);
